/* rtl/scrpaf_pkg.sv */
// shared types, constants and helpers of the thyristor phase angle firing block
package scrpaf_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int OUT_CH       = 4;
  localparam int DUTY_W       = 7;
  localparam int TICK_W       = 8;
  localparam int PERIOD_W     = 8;
  localparam int CH_W         = 2;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 8;

  localparam logic [DUTY_W-1:0] FULL_DUTY  = DUTY_W'(100);
  localparam logic [DUTY_W-1:0] RESET_DUTY = DUTY_W'(50);

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_CROSSING = 2'd1,
    OP_ENABLE   = 2'd2,
    OP_DUTY     = 2'd3
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_POLARITY   = 3'd0,
    REG_SOFT_START = 3'd1,
    REG_TRANSITION = 3'd2,
    REG_START_DUTY = 3'd3,
    REG_RAMP_STEP  = 3'd4,
    REG_RAMP_PER   = 3'd5,
    REG_HOLD       = 3'd6
  } reg_idx_t;

  // settings shared by all channels
  typedef struct packed {
    logic                transition;
    logic [DUTY_W-1:0]   start_duty;
    logic [DUTY_W-1:0]   ramp_step;
    logic [PERIOD_W-1:0] ramp_period;
    logic [DUTY_W-1:0]   hold_ticks;
  } cfg_t;

  // one decoded event as seen by a channel
  typedef struct packed {
    op_t               op;
    logic              en;
    logic [DUTY_W-1:0] duty;
  } evt_t;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
    clamp_duty = (d > FULL_DUTY) ? FULL_DUTY : d;
  endfunction

endpackage

/* rtl/scr_phase_angle_firing.sv */
// top level of the multi channel thyristor phase angle firing block
// an accepted beat passes the input register, then the result register, which drives out_tvalid
// throughput: one event beat per cycle while out_tready stays high
// a result waiting on out_tready lets the input register take one more beat, then in_tready drops
// reset: synchronous active low rst_n; registers return to their defaults, all gates inactive,
// channels closed, target duty 50, no result pending
module scr_phase_angle_firing (
  input  logic                                clk,
  input  logic                                rst_n,
  // event beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [scrpaf_pkg::IN_DATA_W-1:0]    in_tdata,   // opcode[1:0] channel[3:2] enable[4] duty[11:5]
  // result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [scrpaf_pkg::OUT_DATA_W-1:0]   out_tdata,  // gate_levels[3:0] ramp_active_mask[7:4]
  // register writes
  input  logic                                cfg_we,
  input  logic [scrpaf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [scrpaf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [scrpaf_pkg::OUT_CH-1:0] pol_r;
  logic [scrpaf_pkg::OUT_CH-1:0] ss_r;
  scrpaf_pkg::cfg_t              cfg_r;
  logic [scrpaf_pkg::OUT_CH-1:0] ss_new;
  logic [scrpaf_pkg::OUT_CH-1:0] ss_rise;
  logic                          ss_wr;

  // input register stage
  logic                          v1_r;
  scrpaf_pkg::evt_t              evt_r;
  logic [scrpaf_pkg::CH_W-1:0]   ch_r;
  logic                          adv;
  logic                          in_acc;

  // result register
  logic                          out_v_r;
  logic [scrpaf_pkg::OUT_CH-1:0] lvl_r, lvl_nxt;
  logic [scrpaf_pkg::OUT_CH-1:0] act_r, act_nxt;

  logic [scrpaf_pkg::NUM_CHANNELS-1:0] gate_n;
  logic [scrpaf_pkg::NUM_CHANNELS-1:0] act_n;

  // a result moves on when the result register is empty or being drained
  assign adv       = v1_r & (~out_v_r | out_tready);
  assign in_tready = ~v1_r | adv;
  assign in_acc    = in_tvalid & in_tready;

  // soft start write: channels whose bit goes from clear to set restart their ramp
  assign ss_wr   = cfg_we & (cfg_addr == scrpaf_pkg::REG_SOFT_START);
  assign ss_new  = cfg_wdata[scrpaf_pkg::OUT_CH-1:0];
  assign ss_rise = ss_new & ~ss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r             <= '1;
      ss_r              <= '0;
      cfg_r.transition  <= 1'b0;
      cfg_r.start_duty  <= '0;
      cfg_r.ramp_step   <= scrpaf_pkg::DUTY_W'(2);
      cfg_r.ramp_period <= scrpaf_pkg::PERIOD_W'(2);
      cfg_r.hold_ticks  <= scrpaf_pkg::DUTY_W'(2);
    end else if (cfg_we) begin
      case (cfg_addr)
        scrpaf_pkg::REG_POLARITY:   pol_r             <= cfg_wdata[scrpaf_pkg::OUT_CH-1:0];
        scrpaf_pkg::REG_SOFT_START: ss_r              <= ss_new;
        scrpaf_pkg::REG_TRANSITION: cfg_r.transition  <= cfg_wdata[0];
        scrpaf_pkg::REG_START_DUTY: cfg_r.start_duty  <= cfg_wdata[scrpaf_pkg::DUTY_W-1:0];
        scrpaf_pkg::REG_RAMP_STEP:  cfg_r.ramp_step   <= cfg_wdata[scrpaf_pkg::DUTY_W-1:0];
        scrpaf_pkg::REG_RAMP_PER:   cfg_r.ramp_period <= cfg_wdata[scrpaf_pkg::PERIOD_W-1:0];
        scrpaf_pkg::REG_HOLD:       cfg_r.hold_ticks  <= cfg_wdata[scrpaf_pkg::DUTY_W-1:0];
        default:                    pol_r             <= pol_r;
      endcase
    end
  end

  // input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      evt_r.op   <= scrpaf_pkg::op_t'(in_tdata[1:0]);
      ch_r       <= in_tdata[3:2];
      evt_r.en   <= in_tdata[4];
      evt_r.duty <= in_tdata[11:5];
    end
  end

  // one update unit per channel, all working on the same event
  for (genvar i = 0; i < scrpaf_pkg::NUM_CHANNELS; i++) begin : g_ch
    logic sel;
    assign sel = (i < (1 << scrpaf_pkg::CH_W)) &&
                 (ch_r == scrpaf_pkg::CH_W'(i));
    scrpaf_chan u_chan (
      .clk         (clk),
      .rst_n       (rst_n),
      .go          (adv),
      .evt         (evt_r),
      .sel         (sel),
      .cfg         (cfg_r),
      .soft_start  (ss_r[i % scrpaf_pkg::OUT_CH]),
      .cfg_restart (ss_wr & ss_rise[i % scrpaf_pkg::OUT_CH]),
      .gate_nxt    (gate_n[i]),
      .active_nxt  (act_n[i])
    );
  end

  // result fields from the state after the event; a gate shows its polarity when active
  always_comb begin
    lvl_nxt = '0;
    act_nxt = '0;
    for (int i = 0; i < scrpaf_pkg::OUT_CH; i++) begin
      if (i < scrpaf_pkg::NUM_CHANNELS) begin
        lvl_nxt[i] = ~(gate_n[i] ^ pol_r[i]);
        act_nxt[i] = act_n[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lvl_r <= lvl_nxt;
      act_r <= act_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {act_r, lvl_r};

endmodule

/* rtl/scrpaf_chan.sv */
// per channel phase counter, gate pulse timing and soft start ramp
module scrpaf_chan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,          // event applied this cycle
  input  scrpaf_pkg::evt_t    evt,
  input  logic                sel,         // event targets this channel
  input  scrpaf_pkg::cfg_t    cfg,
  input  logic                soft_start,
  input  logic                cfg_restart, // soft start bit newly set
  output logic                gate_nxt,
  output logic                active_nxt
);

  logic [scrpaf_pkg::TICK_W-1:0]   tc_r,  tc_nxt;
  logic                            pd_r,  pd_nxt;
  logic                            open_r, open_nxt;
  logic [scrpaf_pkg::DUTY_W-1:0]   tgt_r, tgt_nxt;
  logic [scrpaf_pkg::DUTY_W-1:0]   rd_r,  rd_nxt;
  logic [scrpaf_pkg::PERIOD_W-1:0] rc_r,  rc_nxt;
  logic                            fin_r, fin_nxt;
  logic                            gate_r, gate_nxt_i;

  logic [scrpaf_pkg::DUTY_W-1:0]   eff;
  logic [scrpaf_pkg::DUTY_W-1:0]   fire;
  logic [scrpaf_pkg::TICK_W-1:0]   tc_inc;
  logic [scrpaf_pkg::TICK_W-1:0]   pulse_end;
  logic [scrpaf_pkg::PERIOD_W-1:0] rc_inc;
  logic [scrpaf_pkg::TICK_W-1:0]   up_sum;
  logic [scrpaf_pkg::DUTY_W-1:0]   down_val;
  logic [scrpaf_pkg::DUTY_W-1:0]   dclamp;
  logic                            ramping;

  always_comb begin
    ramping   = soft_start & ~fin_r;
    eff       = scrpaf_pkg::clamp_duty(ramping ? rd_r : tgt_r);
    fire      = scrpaf_pkg::FULL_DUTY - eff;
    tc_inc    = (tc_r == '1) ? tc_r : tc_r + 1'b1;
    pulse_end = {1'b0, fire} + {1'b0, cfg.hold_ticks};
    rc_inc    = rc_r + 1'b1;
    up_sum    = {1'b0, rd_r} + {1'b0, cfg.ramp_step};
    down_val  = (rd_r > cfg.ramp_step) ? rd_r - cfg.ramp_step : '0;
    dclamp    = scrpaf_pkg::clamp_duty(evt.duty);

    tc_nxt     = tc_r;
    pd_nxt     = pd_r;
    open_nxt   = open_r;
    tgt_nxt    = tgt_r;
    rd_nxt     = rd_r;
    rc_nxt     = rc_r;
    fin_nxt    = fin_r;
    gate_nxt_i = gate_r;

    if (cfg_restart) begin
      fin_nxt = 1'b0;
      rc_nxt  = '0;
      rd_nxt  = scrpaf_pkg::clamp_duty(cfg.start_duty);
    end

    if (go) begin
      case (evt.op)
        scrpaf_pkg::OP_TICK: begin
          if (open_r && !pd_r) begin
            tc_nxt = tc_inc;
            if (tc_inc >= pulse_end) begin
              gate_nxt_i = 1'b0;
              pd_nxt     = 1'b1;
            end else if (tc_inc >= {1'b0, fire}) begin
              gate_nxt_i = 1'b1;
            end else begin
              gate_nxt_i = 1'b0;
            end
          end else begin
            gate_nxt_i = 1'b0;
          end
        end
        scrpaf_pkg::OP_CROSSING: begin
          tc_nxt     = '0;
          gate_nxt_i = 1'b0;
          pd_nxt     = 1'b0;
          if (ramping) begin
            rc_nxt = rc_inc;
            if (cfg.ramp_period <= rc_inc) begin
              rc_nxt = '0;
              if (rd_r < tgt_r) begin
                if (up_sum >= {1'b0, tgt_r}) begin
                  fin_nxt = 1'b1;
                  rd_nxt  = tgt_r;
                end else begin
                  rd_nxt  = up_sum[scrpaf_pkg::DUTY_W-1:0];
                end
              end else begin
                if (down_val <= tgt_r) begin
                  fin_nxt = 1'b1;
                  rd_nxt  = tgt_r;
                end else begin
                  rd_nxt  = down_val;
                end
              end
            end
          end
        end
        scrpaf_pkg::OP_ENABLE: begin
          if (sel) begin
            if (evt.en && !open_r) begin
              fin_nxt = 1'b0;
              rc_nxt  = '0;
              rd_nxt  = scrpaf_pkg::clamp_duty(cfg.start_duty);
            end
            open_nxt = evt.en;
          end
        end
        scrpaf_pkg::OP_DUTY: begin
          if (sel && (dclamp != tgt_r)) begin
            if (cfg.transition) fin_nxt = 1'b0;
            tgt_nxt = dclamp;
          end
        end
        default: begin
          gate_nxt_i = gate_r;
        end
      endcase
    end
  end

  assign gate_nxt   = gate_nxt_i;
  assign active_nxt = soft_start & ~fin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r   <= '0;
      pd_r   <= 1'b1;
      open_r <= 1'b0;
      tgt_r  <= scrpaf_pkg::RESET_DUTY;
      rd_r   <= '0;
      rc_r   <= '0;
      fin_r  <= 1'b0;
      gate_r <= 1'b0;
    end else begin
      tc_r   <= tc_nxt;
      pd_r   <= pd_nxt;
      open_r <= open_nxt;
      tgt_r  <= tgt_nxt;
      rd_r   <= rd_nxt;
      rc_r   <= rc_nxt;
      fin_r  <= fin_nxt;
      gate_r <= gate_nxt_i;
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench of the thyristor phase angle firing block
module tb_top;
  import scrpaf_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_EVENTS = 200;
  localparam int NUM_PHASES   = 6;

  // per channel firing state and shared settings, updated as event beats are accepted
  class firing_scoreboard;
    logic [3:0]  polarity;
    logic [3:0]  soft_mask;
    logic        transition;
    logic [6:0]  start_duty;
    logic [6:0]  ramp_step;
    logic [7:0]  ramp_period;
    logic [6:0]  hold_ticks;
    logic [7:0]  tick_cnt [4];
    logic [6:0]  target [4];
    logic [6:0]  ramp_duty [4];
    logic [7:0]  ramp_cnt [4];
    bit          pulse_done [4];
    bit          ch_open [4];
    bit          ramp_done [4];
    bit          gate_on [4];
    logic [7:0]  results_due [$];
    int unsigned mismatches;
    int unsigned n_events;
    int unsigned n_results;

    function new();
      polarity    = 4'hf;
      soft_mask   = 4'h0;
      transition  = 1'b0;
      start_duty  = 7'd0;
      ramp_step   = 7'd2;
      ramp_period = 8'd2;
      hold_ticks  = 7'd2;
      for (int i = 0; i < 4; i++) begin
        tick_cnt[i]   = 8'd0;
        pulse_done[i] = 1'b1;
        ch_open[i]    = 1'b0;
        target[i]     = RESET_DUTY;
        ramp_duty[i]  = 7'd0;
        ramp_cnt[i]   = 8'd0;
        ramp_done[i]  = 1'b0;
        gate_on[i]    = 1'b0;
      end
      mismatches = 0;
      n_events   = 0;
      n_results  = 0;
    endfunction

    function void restart_ramp(int i);
      ramp_done[i] = 1'b0;
      ramp_cnt[i]  = 8'd0;
      ramp_duty[i] = (start_duty > FULL_DUTY) ? FULL_DUTY : start_duty;
    endfunction

    function void apply_reg(reg_idx_t idx, logic [7:0] v);
      case (idx)
        REG_POLARITY:   polarity = v[3:0];
        REG_SOFT_START: begin
          // newly set bits restart that channel's ramp
          for (int i = 0; i < 4; i++)
            if (v[i] && !soft_mask[i]) restart_ramp(i);
          soft_mask = v[3:0];
        end
        REG_TRANSITION: transition  = v[0];
        REG_START_DUTY: start_duty  = v[6:0];
        REG_RAMP_STEP:  ramp_step   = v[6:0];
        REG_RAMP_PER:   ramp_period = v;
        REG_HOLD:       hold_ticks  = v[6:0];
        default: ;
      endcase
    endfunction

    function void tick_all();
      int unsigned eff;
      int unsigned fire;
      for (int i = 0; i < 4; i++) begin
        if (ch_open[i] && !pulse_done[i]) begin
          eff = (soft_mask[i] && !ramp_done[i]) ? ramp_duty[i] : target[i];
          if (eff > FULL_DUTY) eff = FULL_DUTY;
          fire = FULL_DUTY - eff;
          if (tick_cnt[i] != 8'hff) tick_cnt[i] = tick_cnt[i] + 8'd1;
          if (tick_cnt[i] >= fire + hold_ticks) begin
            gate_on[i]    = 1'b0;
            pulse_done[i] = 1'b1;
          end else begin
            gate_on[i] = (tick_cnt[i] >= fire);
          end
        end else begin
          gate_on[i] = 1'b0;
        end
      end
    endfunction

    function void crossing_all();
      int unsigned cur;
      int unsigned tgt;
      for (int i = 0; i < 4; i++) begin
        tick_cnt[i]   = 8'd0;
        gate_on[i]    = 1'b0;
        pulse_done[i] = 1'b0;
        if (soft_mask[i] && !ramp_done[i]) begin
          ramp_cnt[i] = ramp_cnt[i] + 8'd1;
          if (ramp_period <= ramp_cnt[i]) begin
            cur = ramp_duty[i];
            tgt = target[i];
            ramp_cnt[i] = 8'd0;
            if (cur < tgt) begin
              cur = cur + ramp_step;
              if (cur >= tgt) begin
                ramp_done[i] = 1'b1;
                cur = tgt;
              end
            end else begin
              cur = (cur > ramp_step) ? cur - ramp_step : 0;
              if (cur <= tgt) begin
                ramp_done[i] = 1'b1;
                cur = tgt;
              end
            end
            ramp_duty[i] = 7'(cur);
          end
        end
      end
    endfunction

    function void note_event(logic [15:0] beat);
      op_t        op;
      logic [1:0] ch;
      logic [6:0] d;
      logic [3:0] lv;
      logic [3:0] act;
      op = op_t'(beat[1:0]);
      ch = beat[3:2];
      d  = (beat[11:5] > FULL_DUTY) ? FULL_DUTY : beat[11:5];
      case (op)
        OP_TICK:     tick_all();
        OP_CROSSING: crossing_all();
        OP_ENABLE: begin
          if (beat[4] && !ch_open[ch]) restart_ramp(ch);
          ch_open[ch] = beat[4];
        end
        OP_DUTY: begin
          if (d != target[ch]) begin
            if (transition) ramp_done[ch] = 1'b0;
            target[ch] = d;
          end
        end
        default: ;
      endcase
      for (int i = 0; i < 4; i++) begin
        lv[i]  = gate_on[i] ? polarity[i] : !polarity[i];
        act[i] = soft_mask[i] && !ramp_done[i];
      end
      results_due.push_back({act, lv});
      n_events++;
    endfunction

    function void check_result(logic [7:0] beat);
      logic [7:0] due;
      n_results++;
      if (results_due.size() == 0) begin
        $error("result beat %h arrived with nothing outstanding", beat);
        mismatches++;
        return;
      end
      due = results_due.pop_front();
      if (beat[3:0] !== due[3:0]) begin
        $error("gate_levels: expected %h, actual %h", due[3:0], beat[3:0]);
        mismatches++;
      end
      if (beat[7:4] !== due[7:4]) begin
        $error("ramp_active_mask: expected %h, actual %h", due[7:4], beat[7:4]);
        mismatches++;
      end
    endfunction
  endclass

  // every input driven to a known value from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // opcode[1:0] channel[3:2] enable[4] duty[11:5]
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;         // gate_levels[3:0] ramp_active_mask[7:4]
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // idling odds in percent, changed per phase
  int          in_gap_pct = 0;
  int          stall_pct  = 0;
  int unsigned cycles     = 0;
  int unsigned settings   = 0;
  int          gap_by_phase   [NUM_PHASES] = '{30, 0, 50, 20, 60, 0};
  int          stall_by_phase [NUM_PHASES] = '{20, 0, 40, 30, 10, 0};

  firing_scoreboard sb;

  scr_phase_angle_firing dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** scr_phase_angle_firing: FAILED **");
      $finish;
    end
  end

  // beat monitor: values seen here are the ones present before this edge's updates
  // results are checked before the new event is noted so a stray beat is never masked
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_event(in_tdata);
    end
  end

  // receiver back-pressure: random bursts of stalled cycles at the phase's stall odds
  initial begin
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // one event beat; tvalid stays high into the next beat unless a gap is drawn
  task automatic send_event(op_t op, logic [1:0] ch, logic en, logic [6:0] duty);
    in_tdata  <= {4'b0, duty, en, ch, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // tick or crossing with random don't-care fields
  task automatic send_plain(op_t op);
    send_event(op, 2'($urandom_range(3)), 1'($urandom_range(1)), 7'($urandom_range(127)));
  endtask

  // mostly duties that fire early in the half cycle, plus the ends and the clamped range
  function automatic logic [6:0] pick_duty();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'($urandom_range(101, 127));
      default: return 7'($urandom_range(50, 100));
    endcase
  endfunction

  // register write; we drops again before the task returns, keeping it low between back to back writes
  task automatic program_reg(reg_idx_t idx, logic [7:0] v);
    cfg_addr  <= idx;
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.apply_reg(idx, v);
  endtask

  // first phases hit the register extremes, the rest are random
  task automatic program_settings(int p);
    logic [3:0] pol;
    logic [3:0] ssm;
    logic       tr;
    logic [6:0] sd;
    logic [6:0] st;
    logic [7:0] per;
    logic [6:0] hd;
    pol = 4'($urandom_range(15));
    ssm = 4'($urandom_range(15));
    tr  = 1'($urandom_range(1));
    sd  = 7'($urandom_range(100));
    st  = 7'($urandom_range(30));
    per = 8'($urandom_range(4));
    hd  = 7'($urandom_range(20));
    case (p)
      // active low gates, all ramps restart, zero hold so nothing fires, ramp on every crossing
      0: begin
        pol = 4'h0; ssm = 4'hf; tr = 1'b1; sd = 7'd100; st = 7'd100; per = 8'd0; hd = 7'd0;
      end
      // ramps stalled by the longest period, a hold of 100 ticks
      1: begin
        pol = 4'hf; ssm = 4'ha; tr = 1'b0; sd = 7'd0; st = 7'd1; per = 8'd255; hd = 7'd100;
      end
      // start duty beyond full scale, cleared then set mask bits restart ramps
      2: begin
        pol = 4'h5; ssm = 4'hf; tr = 1'b1; sd = 7'd127; st = 7'd3; per = 8'd1; hd = 7'd5;
      end
      default: ;
    endcase
    program_reg(REG_POLARITY,   {4'b0, pol});
    program_reg(REG_SOFT_START, {4'b0, ssm});
    program_reg(REG_TRANSITION, {7'b0, tr});
    program_reg(REG_START_DUTY, {1'b0, sd});
    program_reg(REG_RAMP_STEP,  {1'b0, st});
    program_reg(REG_RAMP_PER,   per);
    program_reg(REG_HOLD,       {1'b0, hd});
    settings++;
  endtask

  // mains half cycles: a crossing then a run of ticks, with control events sprinkled in
  // and a little noise of arbitrary beats
  task automatic run_mains(int n);
    int sent;
    int ticks;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 5) begin
        send_event(op_t'(2'($urandom_range(3))), 2'($urandom_range(3)),
                   1'($urandom_range(1)), 7'($urandom_range(127)));
        sent++;
      end else begin
        send_plain(OP_CROSSING);
        sent++;
        ticks = ($urandom_range(9) == 0) ? $urandom_range(100, 130) : $urandom_range(5, 50);
        for (int t = 0; t < ticks; t++) begin
          if ($urandom_range(99) < 8) begin
            if ($urandom_range(1) == 0)
              send_event(OP_ENABLE, 2'($urandom_range(3)), $urandom_range(99) < 75,
                         7'($urandom_range(127)));
            else
              send_event(OP_DUTY, 2'($urandom_range(3)), 1'($urandom_range(1)), pick_duty());
            sent++;
          end
          send_plain(OP_TICK);
          sent++;
        end
      end
    end
  endtask

  // close the stream, then wait until every outstanding result has been seen
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset settings
    send_plain(OP_TICK);                          // nothing open, pulses marked done
    send_event(OP_DUTY, 2'd0, 1'b0, 7'd127);      // clamped to full duty
    send_event(OP_DUTY, 2'd1, 1'b1, 7'd0);
    send_event(OP_DUTY, 2'd2, 1'b0, 7'd100);
    send_event(OP_DUTY, 2'd3, 1'b0, 7'd50);       // same as the current target
    send_event(OP_DUTY, 2'd3, 1'b1, 7'd75);
    send_event(OP_ENABLE, 2'd0, 1'b1, 7'd0);
    send_event(OP_ENABLE, 2'd1, 1'b1, 7'd127);
    send_event(OP_ENABLE, 2'd2, 1'b1, 7'd0);
    send_event(OP_ENABLE, 2'd3, 1'b1, 7'd0);
    send_event(OP_ENABLE, 2'd0, 1'b1, 7'd0);      // already open, no restart
    send_plain(OP_CROSSING);
    send_plain(OP_TICK);
    send_event(OP_ENABLE, 2'd2, 1'b0, 7'd0);      // closed mid pulse, level held until the tick
    send_plain(OP_TICK);
    send_plain(OP_TICK);
    send_event(OP_ENABLE, 2'd1, 1'b0, 7'd0);
    send_plain(OP_CROSSING);
    repeat (3) send_plain(OP_TICK);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_settings(p);
      in_gap_pct = gap_by_phase[p];
      stall_pct  = stall_by_phase[p];
      run_mains(PHASE_EVENTS);
      settle();
    end
    repeat (10) @(posedge clk);

    $display("covered %0d event beats and %0d result beats over %0d register settings",
             sb.n_events, sb.n_results, settings);
    $display("polarity, soft start ramps, hold and period extremes with and without idling");
    if (sb.mismatches == 0) begin
      $display("** scr_phase_angle_firing: PASSED **");
    end else begin
      $display("** scr_phase_angle_firing: FAILED **");
    end
    $finish;
  end

endmodule

/* scr_phase_angle_firing.f */
rtl/scrpaf_pkg.sv
rtl/scrpaf_chan.sv
rtl/scr_phase_angle_firing.sv
dv/tb_top.sv
